FILE: rtl/bspl_pkg.sv
// bspl_pkg: shared types and constants for the button short/long press selector
// used by bspl_cfg, bspl_fsm and the top level; no dependencies
package bspl_pkg;

  // field widths
  localparam int unsigned TICK_W = 16;
  localparam int unsigned MODE_W = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // mode count default
  localparam int unsigned MODE_COUNT_DEF = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_MODE = 2'd2;

  // register reset values
  localparam logic [TICK_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'd2000;
  localparam logic [MODE_W-1:0] START_MODE_RST = 6'd0;

  // press phase codes, also reported as press_state
  typedef enum logic [2:0] {
    PH_UNPRESSED = 3'd0,
    PH_BOUNCING  = 3'd1,
    PH_PRESSED   = 3'd2,
    PH_LONG      = 3'd3,
    PH_RELEASING = 3'd4
  } phase_t;

  // configuration as seen by the press machine
  typedef struct packed {
    logic [TICK_W-1:0] debounce_ms;
    logic [TICK_W-1:0] long_press_ms;
    logic [MODE_W-1:0] start_mode;
    logic              mode_load;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [2:0]        press_state;
    logic              power_down_request;
    logic              save_request;
    logic              mode_changed;
    logic [MODE_W-1:0] mode_index;
  } res_t;

endpackage

FILE: rtl/button_short_long_press_selector_unit.sv
// Button short/long press selector: usage notes
//
// Input stream (in_*): one transfer per millisecond tick carrying the sampled
//   button level in in_tdata[0] (0 pressed, 1 released).
// Output stream (out_*): one transfer per input transfer with the mode index,
//   change, save and power-down flags and the press phase after that tick.
// Config port (cfg_*): index 0 debounce_ms, 1 long_press_ms, 2 start_mode;
//   write only while no transfer is in flight. A start_mode write reloads
//   the current mode.
// Pipeline: an item passes the input register, then the result register.
//   Throughput: one transfer per cycle while out_tready stays high, set by
//   the press machine state updating once per accepted transfer.
// Reset (rst_n low, synchronous): both streams empty, registers to defaults,
//   machine unpressed with the countdown cleared.
// Receiver stall: the result register holds; the input register keeps one
//   more item and in_tready drops until the result register frees up.
// depends on bspl_pkg, bspl_cfg, bspl_fsm
module button_short_long_press_selector_unit #(
  parameter int unsigned MODE_COUNT = bspl_pkg::MODE_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bspl_pkg::IN_DATA_W-1:0]    in_tdata,   // [0] button_level, [7:1] zero
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [5:0] mode_index, [6] mode_changed, [7] save_request,
  // [8] power_down_request, [11:9] press_state, [15:12] zero
  output logic [bspl_pkg::OUT_DATA_W-1:0]   out_tdata,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [bspl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bspl_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import bspl_pkg::*;

  cfg_t cfg;
  res_t res;

  logic in_valid_r;
  logic level_r;
  logic res_valid_r;
  res_t res_r;
  logic advance;

  // stage advances when the result register is free or being drained
  assign advance   = in_valid_r && (!res_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  bspl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bspl_fsm #(
    .MODE_COUNT (MODE_COUNT)
  ) u_fsm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .step     (advance),
    .released (level_r),
    .res      (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      level_r <= in_tdata[0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (advance) begin
      res_valid_r <= 1'b1;
    end else if (out_tready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {(OUT_DATA_W - $bits(res_t))'(0), res_r};

`ifndef SYNTHESIS
  a_no_step_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_tready) |-> !advance)
    else $error("press machine stepped while result register was full");
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> res_valid_r)
    else $error("stepped item produced no result");
  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid_r && !out_tready) |=> $stable(res_r))
    else $error("stalled result changed");
`endif

endmodule

FILE: rtl/bspl_cfg.sv
// bspl_cfg: configuration register file written through the plain write port
// depends on bspl_pkg
module bspl_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bspl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bspl_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output bspl_pkg::cfg_t                      cfg
);
  import bspl_pkg::*;

  logic [TICK_W-1:0] debounce_r;
  logic [TICK_W-1:0] long_press_r;
  logic [MODE_W-1:0] start_mode_r;
  logic              mode_load_r;

  // register writes; a start_mode write also reloads the current mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      start_mode_r <= START_MODE_RST;
      mode_load_r  <= 1'b0;
    end else begin
      mode_load_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:   debounce_r <= cfg_wdata[TICK_W-1:0];
          REG_LONG_PRESS: long_press_r <= cfg_wdata[TICK_W-1:0];
          REG_START_MODE: begin
            start_mode_r <= cfg_wdata[MODE_W-1:0];
            mode_load_r  <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign cfg.debounce_ms   = debounce_r;
  assign cfg.long_press_ms = long_press_r;
  assign cfg.start_mode    = start_mode_r;
  assign cfg.mode_load     = mode_load_r;

endmodule

FILE: rtl/bspl_fsm.sv
// bspl_fsm: debounce and press-length state machine with mode selection
// depends on bspl_pkg; state advances once per step, result is combinational
module bspl_fsm #(
  parameter int unsigned MODE_COUNT = bspl_pkg::MODE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bspl_pkg::cfg_t  cfg,
  input  logic            step,
  input  logic            released,
  output bspl_pkg::res_t  res
);
  import bspl_pkg::*;

  localparam logic [MODE_W-1:0] LAST_MODE = MODE_W'(MODE_COUNT - 1);
  localparam logic [MODE_W:0]   WRAP_AT   = (MODE_W + 1)'(MODE_COUNT - 1);

  phase_t            phase_r, phase_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              long_r, long_nxt;

  logic              expire;
  logic [TICK_W-1:0] ticks_dec;
  logic [MODE_W-1:0] mode_cur;
  logic [MODE_W:0]   mode_inc;
  logic              changed, save, power_down;

  // countdown: expires when at most one tick is left
  assign expire    = (ticks_r <= TICK_W'(1));
  assign ticks_dec = expire ? '0 : ticks_r - TICK_W'(1);
  // a start_mode reload pending this cycle is the mode the tick starts from
  assign mode_cur  = cfg.mode_load ? cfg.start_mode : mode_r;
  assign mode_inc  = {1'b0, mode_cur} + (MODE_W + 1)'(1);

  // next state for one tick
  always_comb begin
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    mode_nxt   = mode_cur;
    long_nxt   = long_r;
    changed    = 1'b0;
    save       = 1'b0;
    power_down = 1'b0;
    case (phase_r)
      PH_BOUNCING: begin
        ticks_nxt = ticks_dec;
        if (expire) begin
          if (!released) begin
            ticks_nxt = cfg.long_press_ms;
            phase_nxt = PH_PRESSED;
          end else begin
            phase_nxt = PH_UNPRESSED;
          end
        end
      end
      PH_PRESSED: begin
        if (released) begin
          // short press: advance mode, release beats a same-tick timeout
          ticks_nxt = cfg.debounce_ms;
          phase_nxt = PH_RELEASING;
          mode_nxt  = (mode_inc >= WRAP_AT) ? '0 : mode_inc[MODE_W-1:0];
          changed   = 1'b1;
          save      = 1'b1;
        end else begin
          ticks_nxt = ticks_dec;
          if (expire) begin
            phase_nxt = PH_LONG;
            mode_nxt  = LAST_MODE;
            changed   = 1'b1;
            long_nxt  = 1'b1;
          end
        end
      end
      PH_LONG: begin
        if (released) begin
          ticks_nxt = cfg.debounce_ms;
          phase_nxt = PH_RELEASING;
        end
      end
      PH_RELEASING: begin
        ticks_nxt = ticks_dec;
        if (expire) begin
          if (released) begin
            ticks_nxt = '0;
            phase_nxt = PH_UNPRESSED;
            if (long_r) begin
              power_down = 1'b1;
              long_nxt   = 1'b0;
            end
          end else begin
            // still pressed at the end of release debounce: start over
            ticks_nxt = cfg.debounce_ms;
          end
        end
      end
      default: begin
        phase_nxt = PH_UNPRESSED;
        if (!released) begin
          ticks_nxt = cfg.debounce_ms;
          phase_nxt = PH_BOUNCING;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_UNPRESSED;
      ticks_r <= '0;
      mode_r  <= START_MODE_RST;
      long_r  <= 1'b0;
    end else begin
      if (cfg.mode_load) begin
        mode_r <= cfg.start_mode;
      end
      if (step) begin
        phase_r <= phase_nxt;
        ticks_r <= ticks_nxt;
        mode_r  <= mode_nxt;
        long_r  <= long_nxt;
      end
    end
  end

  // result for this tick, values after the update
  assign res.mode_index         = mode_nxt;
  assign res.mode_changed       = changed;
  assign res.save_request       = save;
  assign res.power_down_request = power_down;
  assign res.press_state        = phase_nxt;

`ifndef SYNTHESIS
  a_save_is_change: assert property (@(posedge clk) disable iff (!rst_n)
    save |-> changed)
    else $error("save request without a mode change");
  a_long_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    (changed && !save) |-> (mode_nxt == LAST_MODE))
    else $error("long press did not select the last mode");
  a_pd_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    power_down |-> (phase_nxt == PH_UNPRESSED && long_r))
    else $error("power down outside a release after long press");
  a_long_seen_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(long_r) |-> (phase_r == PH_LONG))
    else $error("long press flag set outside the long press phase");
`endif

endmodule

FILE: sim/tb_press_pkg.sv
// scoreboard for the button short/long press selector testbench
// tracks the press machine, mode and register values; depends on bspl_pkg
`timescale 1ns / 1ps

package tb_press_pkg;
  import bspl_pkg::*;

  class press_scoreboard;
    // register copies
    logic [TICK_W-1:0] debounce_ticks;
    logic [TICK_W-1:0] long_ticks;
    logic [MODE_W-1:0] start_mode;
    // press machine copy
    phase_t            phase;
    logic [TICK_W-1:0] ticks_left;
    logic [MODE_W-1:0] cur_mode;
    bit                long_seen;
    // per-tick results still owed by the block
    res_t              expected_ticks[$];
    int unsigned       errors;
    int unsigned       checked;
    int unsigned       shorts;
    int unsigned       longs;
    int unsigned       power_downs;

    function new();
      debounce_ticks = DEBOUNCE_RST;
      long_ticks     = LONG_PRESS_RST;
      start_mode     = START_MODE_RST;
      phase          = PH_UNPRESSED;
      ticks_left     = '0;
      cur_mode       = START_MODE_RST;
      long_seen      = 1'b0;
      errors         = 0;
      checked        = 0;
      shorts         = 0;
      longs          = 0;
      power_downs    = 0;
    endfunction

    function int unsigned pending();
      return expected_ticks.size();
    endfunction

    // register write as the block applies it
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_DEBOUNCE:   debounce_ticks = value;
        REG_LONG_PRESS: long_ticks = value;
        REG_START_MODE: begin
          start_mode = value[MODE_W-1:0];
          cur_mode   = start_mode;
        end
        default: ;
      endcase
    endfunction

    // one countdown step, true when it runs out on this tick
    function bit tick_down();
      if (ticks_left <= 1) begin
        ticks_left = '0;
        return 1'b1;
      end
      ticks_left = ticks_left - TICK_W'(1);
      return 1'b0;
    endfunction

    // accepted button sample: advance the machine and queue the result it gives
    function void note_level(logic released);
      res_t            r;
      logic [MODE_W:0] nxt;
      r = '0;
      case (phase)
        PH_BOUNCING: begin
          if (tick_down()) begin
            if (!released) begin
              ticks_left = long_ticks;
              phase      = PH_PRESSED;
            end else begin
              phase = PH_UNPRESSED;
            end
          end
        end
        PH_PRESSED: begin
          // a release on the long-press expiry tick still counts as short
          if (released) begin
            nxt        = {1'b0, cur_mode} + (MODE_W + 1)'(1);
            ticks_left = debounce_ticks;
            phase      = PH_RELEASING;
            if (nxt >= (MODE_W + 1)'(MODE_COUNT_DEF - 1)) begin
              nxt = '0;
            end
            cur_mode        = nxt[MODE_W-1:0];
            r.mode_changed  = 1'b1;
            r.save_request  = 1'b1;
          end else if (tick_down()) begin
            phase          = PH_LONG;
            cur_mode       = MODE_W'(MODE_COUNT_DEF - 1);
            r.mode_changed = 1'b1;
            long_seen      = 1'b1;
          end
        end
        PH_LONG: begin
          if (released) begin
            ticks_left = debounce_ticks;
            phase      = PH_RELEASING;
          end
        end
        PH_RELEASING: begin
          // still pressed when the release window ends: start it over
          if (tick_down()) begin
            if (released) begin
              ticks_left = '0;
              phase      = PH_UNPRESSED;
              if (long_seen) begin
                r.power_down_request = 1'b1;
                long_seen            = 1'b0;
              end
            end else begin
              ticks_left = debounce_ticks;
            end
          end
        end
        default: begin
          phase = PH_UNPRESSED;
          if (!released) begin
            ticks_left = debounce_ticks;
            phase      = PH_BOUNCING;
          end
        end
      endcase
      r.mode_index  = cur_mode;
      r.press_state = phase;
      expected_ticks.push_back(r);
    endfunction

    task report_mismatch(string what, logic [OUT_DATA_W-1:0] got, logic [OUT_DATA_W-1:0] want);
      $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", checked, what, got, want);
      errors++;
    endtask

    // accepted result transfer against the oldest expectation
    task check_result(logic [OUT_DATA_W-1:0] data);
      res_t got;
      res_t want;
      if (expected_ticks.size() == 0) begin
        report_mismatch("result with nothing expected", data, '0);
        return;
      end
      want = expected_ticks.pop_front();
      got  = res_t'(data[$bits(res_t)-1:0]);
      checked++;
      if (got.mode_index !== want.mode_index)
        report_mismatch("mode_index", OUT_DATA_W'(got.mode_index),
                        OUT_DATA_W'(want.mode_index));
      if (got.mode_changed !== want.mode_changed)
        report_mismatch("mode_changed", OUT_DATA_W'(got.mode_changed),
                        OUT_DATA_W'(want.mode_changed));
      if (got.save_request !== want.save_request)
        report_mismatch("save_request", OUT_DATA_W'(got.save_request),
                        OUT_DATA_W'(want.save_request));
      if (got.power_down_request !== want.power_down_request)
        report_mismatch("power_down_request", OUT_DATA_W'(got.power_down_request),
                        OUT_DATA_W'(want.power_down_request));
      if (got.press_state !== want.press_state)
        report_mismatch("press_state", OUT_DATA_W'(got.press_state),
                        OUT_DATA_W'(want.press_state));
      if (data[OUT_DATA_W-1:$bits(res_t)] !== '0)
        report_mismatch("padding bits", data, OUT_DATA_W'(want));
      if (want.save_request) shorts++;
      else if (want.mode_changed) longs++;
      if (want.power_down_request) power_downs++;
    endtask
  endclass

endpackage

FILE: sim/tb_top.sv
// top-level testbench for button_short_long_press_selector_unit
// drives button samples and register writes, checks every result via tb_press_pkg
`timescale 1ns / 1ps

module tb_top;
  import bspl_pkg::*;
  import tb_press_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  // short/long presses, bounce that settles released, release on the
  // long-press expiry tick, release window ending pressed, wrap past the top
  localparam bit [0:22] DIRECTED_LEVELS = 23'b01001100010100000110011;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  press_scoreboard sb;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     levels_sent;
  int unsigned     cfg_writes;
  int unsigned     stall_cycles;
  int unsigned     cur_debounce;
  int unsigned     cur_long;

  button_short_long_press_selector_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_level(in_tdata[0]);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results owed",
               stall_cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one button sample, with a random gap in front
  task automatic send_level(input logic lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(lvl);
    do @(posedge clk); while (!in_tready);
    levels_sent++;
    @(negedge clk);
  endtask

  task automatic hold_level(input logic lvl, input int unsigned count);
    repeat (count) send_level(lvl);
  endtask

  // drain everything in flight, then let the pipeline settle
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    @(posedge clk);
    sb.write_reg(idx, CFG_DATA_W'(value));
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    if (idx == REG_DEBOUNCE) cur_debounce = value;
    if (idx == REG_LONG_PRESS) cur_long = value;
  endtask

  // press with chatter, held short, near the long-press edge or long
  task automatic press_gesture();
    int unsigned span;
    int unsigned lo;
    int unsigned hold;
    span = cur_debounce + cur_long;
    lo   = (span > 2) ? span - 2 : 1;
    repeat ($urandom_range(3)) send_level(1'($urandom_range(1)));
    case ($urandom_range(2))
      0:       hold = $urandom_range(span, 1);
      1:       hold = $urandom_range(span + 2, lo);
      default: hold = $urandom_range(span + 12, span + 1);
    endcase
    hold_level(1'b0, hold);
    repeat ($urandom_range(3)) send_level(1'($urandom_range(1)));
    hold_level(1'b1, $urandom_range(cur_debounce + 3, 1));
  endtask

  task automatic random_phase(input int unsigned deb, input int unsigned lp,
                              input int unsigned start, input int unsigned count);
    int unsigned target;
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_START_MODE, start);
    target = levels_sent + count;
    while (levels_sent < target) begin
      if ($urandom_range(9) < 8) begin
        press_gesture();
      end else begin
        repeat ($urandom_range(4, 1)) send_level(1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    int k;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_DEBOUNCE;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    levels_sent  = 0;
    cfg_writes   = 0;
    cur_debounce = 32'(DEBOUNCE_RST);
    cur_long     = 32'(LONG_PRESS_RST);
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset register values, no idling on either side
    hold_level(1'b0, cur_debounce + 10);
    hold_level(1'b1, cur_debounce + 10);
    tx_idle_pct = 7;
    rx_idle_pct = 7;

    // directed corner cases at the shortest timings
    write_reg(REG_DEBOUNCE, 1);
    write_reg(REG_LONG_PRESS, 2);
    write_reg(REG_START_MODE, 5);
    for (k = 0; k < 23; k++) send_level(DIRECTED_LEVELS[k]);
    write_reg(REG_START_MODE, 62);
    hold_level(1'b0, 2);
    hold_level(1'b1, 2);

    // random gestures over several settings
    random_phase(1, 1, 0, 300);
    random_phase(3, 10, 62, 300);
    repeat (3) begin
      random_phase($urandom_range(6, 1), $urandom_range(25, 2), $urandom_range(62, 0), 250);
    end
    random_phase(2, 4, 7, 200);

    // largest timings: a short press under the longest long-press time,
    // then a slow debounce
    random_phase(1, 65535, 6, 0);
    hold_level(1'b0, 20);
    hold_level(1'b1, 4);
    write_reg(REG_DEBOUNCE, 65535);
    repeat (40) send_level(1'($urandom_range(1)));

    wait_idle();
    repeat (10) @(posedge clk);
    $display("run covered %0d button samples, %0d results checked, %0d register writes",
             levels_sent, sb.checked, cfg_writes);
    $display("short presses %0d, long presses %0d, power-down flags %0d",
             sb.shorts, sb.longs, sb.power_downs);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/bspl_pkg.sv
rtl/bspl_cfg.sv
rtl/bspl_fsm.sv
rtl/button_short_long_press_selector_unit.sv
sim/tb_press_pkg.sv
sim/tb_top.sv
